// File: rtl/core/epbg_pkg.sv
// Shared types and constants of the entropy pool byte generator.
package epbg_pkg;

    // Command selector carried on the input tuser
    typedef enum logic [1:0] {
        CMD_SEED = 2'd0,
        CMD_FILL = 2'd1,
        CMD_GET  = 2'd2,
        CMD_ADD  = 2'd3
    } cmd_t;

    // Generator step constants
    localparam logic [63:0] GEN_RESET = 64'h1234_5678_9ABC_DEF0;
    localparam logic [30:0] GEN_MUL   = 31'd1103515245;
    localparam logic [63:0] GEN_ADD   = 64'd12345;
    localparam int          GEN_ROT   = 13;

    // Call position wraps at this width on get
    localparam int GET_POS_W = 13;

    localparam int POOL_DEPTH_DEFAULT = 4096;

    // Beat layouts
    localparam int IN_TDATA_W  = 200;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 72;

    // Generator control from the sequencer
    typedef struct packed {
        logic        load;
        logic        step;
        logic [63:0] seed;
        logic [63:0] tick;
    } gen_ctl_t;

endpackage

// File: rtl/core/epbg_gen.sv
// Two-stage 64-bit multiply-add-xor-rotate generator holding its own state.
module epbg_gen (
    input  logic               clk,
    input  logic               rst_n,
    input  epbg_pkg::gen_ctl_t ctl,
    output logic [63:0]        value
);

    logic [63:0] state_reg;
    logic [63:0] state_next;
    logic [62:0] prod_lo_reg;
    logic [62:0] prod_lo_next;
    logic [31:0] prod_hi_reg;
    logic [31:0] prod_hi_next;
    logic [63:0] sum;
    logic [63:0] mixed;

    // Split the 64x31 product over the two 32-bit halves of the state; only the low word of the
    // upper partial product survives the 64-bit wrap.
    always_comb
    begin
        prod_lo_next = 63'(state_reg[31:0]) * 63'(epbg_pkg::GEN_MUL);
        prod_hi_next = state_reg[63:32] * 32'(epbg_pkg::GEN_MUL);
    end

    always_ff @(posedge clk)
    begin
        prod_lo_reg <= prod_lo_next;
        prod_hi_reg <= prod_hi_next;
    end

    always_comb
    begin
        sum   = {prod_hi_reg, 32'd0} + 64'(prod_lo_reg) + epbg_pkg::GEN_ADD;
        mixed = sum ^ ctl.tick;
        value = {mixed[63-epbg_pkg::GEN_ROT:0], mixed[63:64-epbg_pkg::GEN_ROT]};
    end

    always_comb
    begin
        state_next = state_reg;
        if (ctl.load)
        begin
            state_next = ctl.seed;
        end
        else if (ctl.step)
        begin
            state_next = value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= epbg_pkg::GEN_RESET;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/core/epbg_pool.sv
// Byte pool memory: one write and one registered read port with write forwarding.
module epbg_pool #(
    parameter int POOL_DEPTH = epbg_pkg::POOL_DEPTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [$clog2(POOL_DEPTH)-1:0] raddr,
    output logic [7:0]                    rdata,
    input  logic                          we,
    input  logic [$clog2(POOL_DEPTH)-1:0] waddr,
    input  logic [7:0]                    wdata
);

    logic [7:0] pool_mem [POOL_DEPTH];
    logic [7:0] rd_data_reg;
    logic [7:0] fwd_data_reg;
    logic       fwd_reg;
    logic       fwd_next;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            pool_mem[waddr] <= wdata;
        end
        rd_data_reg <= pool_mem[raddr];
    end

    // The array returns old data on a same-address write; take the new byte instead
    assign fwd_next = we && (waddr == raddr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else
        begin
            fwd_reg <= fwd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= wdata;
    end

    assign rdata = fwd_reg ? fwd_data_reg : rd_data_reg;

endmodule

// File: rtl/core/epbg_out_buf.sv
// Two-entry result buffer driving the master-side stream.
module epbg_out_buf (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    input  logic [epbg_pkg::OUT_TDATA_W-1:0]   push_data,
    output logic                               full,
    output logic                               tvalid,
    input  logic                               tready,
    output logic [epbg_pkg::OUT_TDATA_W-1:0]   tdata
);

    logic [1:0]                           count_reg;
    logic [1:0]                           count_next;
    logic [epbg_pkg::OUT_TDATA_W-1:0]     slot0_reg;
    logic [epbg_pkg::OUT_TDATA_W-1:0]     slot0_next;
    logic [epbg_pkg::OUT_TDATA_W-1:0]     slot1_reg;
    logic [epbg_pkg::OUT_TDATA_W-1:0]     slot1_next;
    logic                                 pop;

    assign pop    = tvalid && tready;
    assign tvalid = (count_reg != 2'd0);
    assign full   = (count_reg == 2'd2);
    assign tdata  = slot0_reg;

    always_comb
    begin
        count_next = count_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (push && !pop)
        begin
            if (count_reg == 2'd0)
            begin
                slot0_next = push_data;
            end
            else
            begin
                slot1_next = push_data;
            end
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            slot0_next = slot1_reg;
            count_next = count_reg - 2'd1;
        end
        else if (pop && push)
        begin
            if (count_reg == 2'd1)
            begin
                slot0_next = push_data;
            end
            else
            begin
                slot0_next = slot1_reg;
                slot1_next = push_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

// File: rtl/core/entropy_pool_byte_generator.sv
// A get or add result goes through the s1 registers and the result buffer to the master side.
// Input waits while an item holds s1, as set by the two-stage generator multiply
//   (partial products, then combine) and the single write port of the pool memory.
// One result waiting on the master side does not stall input; hold input off once two wait.
// Reset: pointers, call position and byte tally clear, the generator loads its fixed seed;
//   pool contents stay undefined until written, with no clearing pass.
module entropy_pool_byte_generator #(
    parameter int POOL_DEPTH = epbg_pkg::POOL_DEPTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // seed_value, tick_for_generator, tick_for_mixing, entropy_byte
    input  logic [epbg_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // cmd, first_of_call
    input  logic [epbg_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // random_byte, bytes_consumed
    output logic [epbg_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    localparam int PTR_W = $clog2(POOL_DEPTH);
    // Wide enough for the get wrap and for an add call that runs up to the pool depth
    localparam int POS_W = ($clog2(POOL_DEPTH + 1) > epbg_pkg::GET_POS_W) ?
                           $clog2(POOL_DEPTH + 1) : epbg_pkg::GET_POS_W;
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(POOL_DEPTH - 1);
    localparam logic [POS_W-1:0] DEPTH_POS = POS_W'(POOL_DEPTH);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    // Input beat fields
    epbg_pkg::cmd_t in_cmd;
    logic           in_first;
    logic [63:0]    in_seed;
    logic [63:0]    in_tgen;
    logic [63:0]    in_tmix;
    logic [7:0]     in_data;
    logic           accept;

    // Registered fields of an accepted item (s1)
    logic           s1_valid_reg;
    epbg_pkg::cmd_t s1_cmd_reg;
    logic           s1_first_reg;
    logic [63:0]    s1_seed_reg;
    logic [63:0]    s1_tgen_reg;
    logic [7:0]     s1_fold_reg;
    logic [7:0]     s1_data_reg;

    // Deferred tick mix into the entry after a get
    logic             s2_valid_reg;
    logic             s2_valid_next;
    logic [PTR_W-1:0] s2_addr_reg;
    logic [7:0]       s2_fold_reg;

    // Architectural state outside the pool
    logic [PTR_W-1:0] pool_ptr_reg;
    logic [PTR_W-1:0] pool_ptr_next;
    logic [PTR_W-1:0] fill_ptr_reg;
    logic [PTR_W-1:0] fill_ptr_next;
    logic [POS_W-1:0] call_pos_reg;
    logic [POS_W-1:0] call_pos_next;
    logic [63:0]      tally_reg;
    logic [63:0]      tally_next;

    logic [PTR_W-1:0] pool_ptr_inc;
    logic [PTR_W-1:0] fill_ptr_inc;
    logic [POS_W-1:0] pos_eff;
    logic [POS_W-1:0] pos_inc;

    // Pool and generator hook-up
    logic [PTR_W-1:0]   rd_addr;
    logic [7:0]         rd_data;
    logic               wr_en;
    logic [PTR_W-1:0]   wr_addr;
    logic [7:0]         wr_data;
    logic [7:0]         mixed_byte;
    epbg_pkg::gen_ctl_t gen_ctl;
    logic [63:0]        gen_value;

    // Result path
    logic                             push;
    logic [7:0]                       push_byte;
    logic                             out_full;
    logic [epbg_pkg::OUT_TDATA_W-1:0] push_data;

    assign in_cmd   = epbg_pkg::cmd_t'(s_axis_tuser[1:0]);
    assign in_first = s_axis_tuser[2];
    assign in_seed  = s_axis_tdata[63:0];
    assign in_tgen  = s_axis_tdata[127:64];
    assign in_tmix  = s_axis_tdata[191:128];
    assign in_data  = s_axis_tdata[199:192];

    // Take a beat only while no item holds s1 and while the result buffer has room
    assign s_axis_tready = !s1_valid_reg && !out_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg   <= in_cmd;
            s1_first_reg <= in_first;
            s1_seed_reg  <= in_seed;
            s1_tgen_reg  <= in_tgen;
            // Fold the mixing tick down to one byte now; only its low three bytes are used
            s1_fold_reg  <= in_tmix[7:0] ^ in_tmix[15:8] ^ in_tmix[23:16];
            s1_data_reg  <= in_data;
        end
    end

    // Generator: partial products run in the beat cycle, the step completes in the next
    always_comb
    begin
        gen_ctl.load = s1_valid_reg && (s1_cmd_reg == epbg_pkg::CMD_SEED);
        gen_ctl.step = s1_valid_reg && ((s1_cmd_reg == epbg_pkg::CMD_FILL) ||
                                        (s1_cmd_reg == epbg_pkg::CMD_GET));
        gen_ctl.seed = s1_seed_reg;
        gen_ctl.tick = s1_tgen_reg;
    end

    epbg_gen u_gen (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (gen_ctl),
        .value (gen_value)
    );

    assign pool_ptr_inc = ptr_inc(pool_ptr_reg);
    assign fill_ptr_inc = ptr_inc(fill_ptr_reg);

    // Read the current entry in the beat cycle, the neighbouring entry in the next
    assign rd_addr = s1_valid_reg ? pool_ptr_inc : pool_ptr_reg;

    epbg_pool #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_pool (
        .clk   (clk),
        .rst_n (rst_n),
        .raddr (rd_addr),
        .rdata (rd_data),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data)
    );

    assign pos_eff    = s1_first_reg ? '0 : call_pos_reg;
    assign pos_inc    = pos_eff + POS_W'(1);
    assign mixed_byte = rd_data ^ gen_value[7:0];

    // Item sequencing. The deferred mix write and an item's own write never share a
    // cycle: the deferred write lands in the cycle after a get, when no item holds s1.
    always_comb
    begin
        pool_ptr_next = pool_ptr_reg;
        fill_ptr_next = fill_ptr_reg;
        call_pos_next = call_pos_reg;
        tally_next    = tally_reg;
        s2_valid_next = 1'b0;
        push          = 1'b0;
        push_byte     = 8'd0;
        wr_en         = s2_valid_reg;
        wr_addr       = s2_addr_reg;
        wr_data       = rd_data ^ s2_fold_reg;

        if (s1_valid_reg)
        begin
            unique case (s1_cmd_reg)
                epbg_pkg::CMD_SEED:
                begin
                    fill_ptr_next = '0;
                end
                epbg_pkg::CMD_FILL:
                begin
                    wr_en         = 1'b1;
                    wr_addr       = fill_ptr_reg;
                    wr_data       = gen_value[7:0];
                    fill_ptr_next = fill_ptr_inc;
                end
                epbg_pkg::CMD_GET:
                begin
                    wr_en         = 1'b1;
                    wr_addr       = pool_ptr_reg;
                    wr_data       = mixed_byte;
                    pool_ptr_next = pool_ptr_inc;
                    // Mix the tick into the next entry on every eighth byte of a call
                    s2_valid_next = (pos_eff[2:0] == 3'd0);
                    call_pos_next = POS_W'(pos_inc[epbg_pkg::GET_POS_W-1:0]);
                    tally_next    = tally_reg + 64'd1;
                    push          = 1'b1;
                    push_byte     = mixed_byte;
                end
                epbg_pkg::CMD_ADD:
                begin
                    // Past the pool depth, an add call leaves the pool alone
                    if (pos_eff < DEPTH_POS)
                    begin
                        wr_en         = 1'b1;
                        wr_addr       = pool_ptr_reg;
                        wr_data       = rd_data ^ s1_data_reg;
                        pool_ptr_next = pool_ptr_inc;
                        call_pos_next = pos_inc;
                    end
                    else
                    begin
                        call_pos_next = pos_eff;
                    end
                    tally_next = tally_reg + 64'd1;
                    push       = 1'b1;
                end
                default:
                begin
                    fill_ptr_next = fill_ptr_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            pool_ptr_reg <= '0;
            fill_ptr_reg <= '0;
            call_pos_reg <= '0;
            tally_reg    <= 64'd0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s2_valid_next;
            pool_ptr_reg <= pool_ptr_next;
            fill_ptr_reg <= fill_ptr_next;
            call_pos_reg <= call_pos_next;
            tally_reg    <= tally_next;
        end
    end

    // Hold the address and folded tick for the deferred write
    always_ff @(posedge clk)
    begin
        if (s2_valid_next)
        begin
            s2_addr_reg <= pool_ptr_inc;
            s2_fold_reg <= s1_fold_reg;
        end
    end

    assign push_data = {tally_next, push_byte};

    epbg_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (out_full),
        .tvalid    (m_axis_tvalid),
        .tready    (m_axis_tready),
        .tdata     (m_axis_tdata)
    );

endmodule
